// File: sv/wte_pkg.sv
// Package with the payload types, constants and helper functions of the wind triangle estimator.
package wte_pkg;

  // Width of the internal velocity datapath (Q16 of 1/128 m/s with headroom).
  localparam int unsigned CW = 40;
  // Number of entries in the arctangent table.
  localparam int unsigned ATAN_ENTRIES = 24;
  // Reciprocal of the CORDIC gain in Q30.
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  // Reset value of the minimum airspeed register.
  localparam logic [14:0] MIN_AIRSPEED_RESET = 15'd1280;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_e;

  // One input item.
  typedef struct packed {
    logic signed [15:0] ground_vel_north;
    logic signed [15:0] ground_vel_east;
    logic signed [15:0] ground_vel_down;
    logic        [15:0] heading_angle;
    logic signed [15:0] pitch_angle;
    logic        [14:0] true_airspeed;
  } in_t;

  // One result item.
  typedef struct packed {
    logic               valid_res;
    logic        [15:0] wind_speed;
    logic        [15:0] wind_from_dir;
    logic signed [15:0] wind_vertical;
  } res_t;

  // Sideband carried alongside the pitch rotation.
  typedef struct packed {
    logic signed [15:0] gn;
    logic signed [15:0] ge;
    logic signed [15:0] gd;
    logic        [15:0] heading;
    logic               ok;
  } side_a_t;

  // Sideband carried alongside the heading rotation.
  typedef struct packed {
    logic signed [15:0] gn;
    logic signed [15:0] ge;
    logic        [15:0] heading;
    logic signed [15:0] up;
    logic               ok;
  } side_b_t;

  // Sideband carried alongside the vectoring pass.
  typedef struct packed {
    logic signed [15:0] up;
    logic               calm;
    logic               ok;
  } side_c_t;

  // Sideband carried alongside the final gain correction.
  typedef struct packed {
    logic        [15:0] dir;
    logic signed [15:0] up;
    logic               calm;
    logic               ok;
  } side_d_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Round half up from Q16 and saturate to a signed 16-bit value.
  function automatic logic signed [15:0] round_sat_s16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic signed [15:0]   o;
    t = v + CW'(32768);
    r = t >>> 16;
    if (r > CW'(32767)) begin
      o = 16'sh7FFF;
    end else if (r < -CW'(32768)) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  // Round half up from Q16 and saturate to an unsigned 16-bit value.
  function automatic logic [15:0] round_sat_u16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic        [15:0]   o;
    t = v + CW'(32768);
    r = t >>> 16;
    if (r > CW'(65535)) begin
      o = 16'hFFFF;
    end else if (r < 0) begin
      o = 16'h0000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage

// File: sv/wte_unscale.sv
// Two-stage multiplier that removes the CORDIC gain from a signed value, flooring the result.
module wte_unscale #(
  parameter int unsigned SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          v_i,
  input  logic signed [wte_pkg::CW-1:0] d_i,
  input  logic        [SW-1:0]          side_i,
  output logic                          v_o,
  output logic signed [wte_pkg::CW-1:0] d_o,
  output logic        [SW-1:0]          side_o
);

  localparam int unsigned LW = wte_pkg::CW / 2;
  localparam int unsigned HW = wte_pkg::CW - LW;
  localparam int unsigned PW = wte_pkg::CW + 30;

  logic                      va_q, vb_q;
  logic                      neg_q;
  logic [LW+29:0]            lo_q;
  logic [HW+29:0]            hi_q;
  logic [SW-1:0]             sa_q, sb_q;
  logic signed [wte_pkg::CW-1:0] d_q;
  logic [wte_pkg::CW-1:0]    mag;
  logic [PW-1:0]             prod;
  logic [PW-1:0]             adj;
  logic [wte_pkg::CW-1:0]    shr;
  logic signed [wte_pkg::CW-1:0] d_d;

  // Magnitude of the operand, split into two halves for the partial products.
  assign mag = d_i[wte_pkg::CW-1] ? wte_pkg::CW'(-d_i) : wte_pkg::CW'(d_i);

  // Sum of the partial products, then a floor shift in the operand's sign.
  always_comb begin
    prod = {hi_q, {LW{1'b0}}} + PW'(lo_q);
    adj  = neg_q ? (prod + PW'(32'h3FFF_FFFF)) : prod;
    shr  = adj[PW-1:30];
    d_d  = neg_q ? -$signed(shr) : $signed(shr);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= v_i;
      vb_q <= va_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    neg_q <= d_i[wte_pkg::CW-1];
    lo_q  <= mag[LW-1:0] * wte_pkg::INV_GAIN_Q30;
    hi_q  <= mag[wte_pkg::CW-1:LW] * wte_pkg::INV_GAIN_Q30;
    sa_q  <= side_i;
    d_q   <= d_d;
    sb_q  <= sa_q;
  end

  assign v_o    = vb_q;
  assign d_o    = d_q;
  assign side_o = sb_q;

endmodule

// File: sv/wte_cordic.sv
// Fully pipelined CORDIC in rotation or vectoring mode, one stage per register.
module wte_cordic #(
  parameter int unsigned           STAGES = 16,
  parameter wte_pkg::cordic_mode_e MODE   = wte_pkg::CORDIC_ROTATE,
  parameter int unsigned           SW     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          v_i,
  input  logic signed [wte_pkg::CW-1:0] x_i,
  input  logic signed [wte_pkg::CW-1:0] y_i,
  input  logic        [31:0]            z_i,
  input  logic        [SW-1:0]          side_i,
  output logic                          v_o,
  output logic signed [wte_pkg::CW-1:0] x_o,
  output logic signed [wte_pkg::CW-1:0] y_o,
  output logic        [31:0]            z_o,
  output logic        [SW-1:0]          side_o
);

  logic        [STAGES:0]         v_q;
  logic signed [wte_pkg::CW-1:0]  x_q [STAGES+1];
  logic signed [wte_pkg::CW-1:0]  y_q [STAGES+1];
  logic        [31:0]             z_q [STAGES+1];
  logic        [SW-1:0]           s_q [STAGES+1];
  logic signed [wte_pkg::CW-1:0]  x0_d, y0_d;
  logic        [31:0]             z0_d;
  logic        [31:0]             zq;

  // Fold the operand into the right half-plane before the iterations.
  always_comb begin
    zq = z_i + wte_pkg::QUARTER_TURN;
    if (MODE == wte_pkg::CORDIC_ROTATE) begin
      if (zq >= wte_pkg::HALF_TURN) begin
        x0_d = -x_i;
        y0_d = -y_i;
        z0_d = z_i + wte_pkg::HALF_TURN;
      end else begin
        x0_d = x_i;
        y0_d = y_i;
        z0_d = z_i;
      end
    end else begin
      if (x_i[wte_pkg::CW-1]) begin
        x0_d = -x_i;
        y0_d = -y_i;
        z0_d = wte_pkg::HALF_TURN;
      end else begin
        x0_d = x_i;
        y0_d = y_i;
        z0_d = '0;
      end
    end
  end

  // Fold stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= v_i;
    end
  end

  // Fold stage payload.
  always_ff @(posedge clk_i) begin
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    z_q[0] <= z0_d;
    s_q[0] <= side_i;
  end

  // One micro-rotation per pipeline stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [wte_pkg::CW-1:0] dx, dy;
    logic                          up;
    logic        [31:0]            at;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = wte_pkg::atan_angle(5'(i));
    assign up = (MODE == wte_pkg::CORDIC_ROTATE) ? !z_q[i][31] : !y_q[i][wte_pkg::CW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      s_q[i+1] <= s_q[i];
      if (MODE == wte_pkg::CORDIC_ROTATE) begin
        if (up) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end else begin
        if (up) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end
      end
    end
  end

  assign v_o    = v_q[STAGES];
  assign x_o    = x_q[STAGES];
  assign y_o    = y_q[STAGES];
  assign z_o    = z_q[STAGES];
  assign side_o = s_q[STAGES];

endmodule

// File: sv/wind_triangle_estimator_unit.sv
// Top level of the wind triangle estimator: input register, rotations, vectoring and output.
//
// The block takes one sample in every clock cycle and never raises busy_o. Each sample gives
// one result on res_o, marked by res_valid_o for one cycle. On its way the sample passes the
// input register, the three CORDIC pipelines (pitch rotation, heading rotation, vectoring),
// each one fold stage plus one stage per iteration, with a two-stage gain correction
// multiplier ahead of each of the first two and behind the last, the wind difference register
// and the output register. The minimum airspeed register is written with cfg_we_i.
module wind_triangle_estimator_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  wte_pkg::in_t   item_i,
  input  logic           cfg_we_i,
  input  logic [14:0]    cfg_wdata_i,
  output logic           res_valid_o,
  output wte_pkg::res_t  res_o
);

  localparam int unsigned CW  = wte_pkg::CW;
  localparam int unsigned SAW = $bits(wte_pkg::side_a_t);
  localparam int unsigned SBW = $bits(wte_pkg::side_b_t);
  localparam int unsigned SCW = $bits(wte_pkg::side_c_t);
  localparam int unsigned SDW = $bits(wte_pkg::side_d_t);

  logic [14:0] min_q;

  // Input stage.
  logic                in_v_q;
  logic signed [CW-1:0] in_x_q;
  logic [31:0]         pitch_q;
  wte_pkg::side_a_t    in_s_q;

  // Pitch rotation path.
  logic                u1_v;
  logic signed [CW-1:0] u1_d;
  logic [SAW-1:0]      u1_s;
  logic [31:0]         r1_z_in;
  logic                r1_v;
  logic signed [CW-1:0] r1_x, r1_y;
  logic [31:0]         r1_z;
  logic [SAW-1:0]      r1_s;
  wte_pkg::side_a_t    r1_side;
  wte_pkg::side_b_t    u2_side_in;
  logic signed [CW-1:0] up_full;

  // Heading rotation path.
  logic                u2_v;
  logic signed [CW-1:0] u2_d;
  logic [SBW-1:0]      u2_s;
  wte_pkg::side_b_t    u2_side;
  logic                r2_v;
  logic signed [CW-1:0] r2_x, r2_y;
  logic [31:0]         r2_z;
  logic [SBW-1:0]      r2_s;
  wte_pkg::side_b_t    r2_side;

  // Wind difference stage.
  logic                w_v_q;
  logic signed [CW-1:0] w_x_q, w_y_q;
  wte_pkg::side_c_t    w_s_q;
  logic signed [CW-1:0] w_x_d, w_y_d;

  // Vectoring path.
  logic                r3_v;
  logic signed [CW-1:0] r3_x, r3_y;
  logic [31:0]         r3_z;
  logic [SCW-1:0]      r3_s;
  wte_pkg::side_c_t    r3_side;
  wte_pkg::side_d_t    u3_side_in;
  logic [31:0]         dir_rnd;
  logic                u3_v;
  logic signed [CW-1:0] u3_d;
  logic [SDW-1:0]      u3_s;
  wte_pkg::side_d_t    u3_side;

  // Output stage.
  logic                out_v_q;
  wte_pkg::res_t       out_q;
  wte_pkg::res_t       out_d;

  assign busy_o = 1'b0;

  // Minimum airspeed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= wte_pkg::MIN_AIRSPEED_RESET;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  // Input register: airspeed to Q16, angles to 32-bit binary angles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_x_q         <= $signed({{(CW-31){1'b0}}, item_i.true_airspeed, 16'b0});
    pitch_q        <= {item_i.pitch_angle, 16'b0};
    in_s_q.gn      <= item_i.ground_vel_north;
    in_s_q.ge      <= item_i.ground_vel_east;
    in_s_q.gd      <= item_i.ground_vel_down;
    in_s_q.heading <= item_i.heading_angle;
    in_s_q.ok      <= item_i.true_airspeed >= min_q;
  end

  // Gain correction ahead of the pitch rotation, which needs the angle as sideband too.
  wte_unscale #(.SW(SAW + 32)) u_unscale_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (in_v_q),
    .d_i    (in_x_q),
    .side_i ({in_s_q, pitch_q}),
    .v_o    (u1_v),
    .d_o    (u1_d),
    .side_o ({u1_s, r1_z_in})
  );

  wte_cordic #(
    .STAGES (CORDIC_STAGES),
    .MODE   (wte_pkg::CORDIC_ROTATE),
    .SW     (SAW)
  ) u_cordic_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (u1_v),
    .x_i    (u1_d),
    .y_i    ('0),
    .z_i    (r1_z_in),
    .side_i (u1_s),
    .v_o    (r1_v),
    .x_o    (r1_x),
    .y_o    (r1_y),
    .z_o    (r1_z),
    .side_o (r1_s)
  );

  // Upward wind from the vertical ground speed and the climb part of the airspeed.
  always_comb begin
    r1_side            = wte_pkg::side_a_t'(r1_s);
    up_full            = -($signed({{(CW-32){r1_side.gd[15]}}, r1_side.gd, 16'b0}) + r1_y);
    u2_side_in.gn      = r1_side.gn;
    u2_side_in.ge      = r1_side.ge;
    u2_side_in.heading = r1_side.heading;
    u2_side_in.up      = wte_pkg::round_sat_s16(up_full);
    u2_side_in.ok      = r1_side.ok;
  end

  wte_unscale #(.SW(SBW)) u_unscale_heading (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (r1_v),
    .d_i    (r1_x),
    .side_i (u2_side_in),
    .v_o    (u2_v),
    .d_o    (u2_d),
    .side_o (u2_s)
  );

  assign u2_side = wte_pkg::side_b_t'(u2_s);

  wte_cordic #(
    .STAGES (CORDIC_STAGES),
    .MODE   (wte_pkg::CORDIC_ROTATE),
    .SW     (SBW)
  ) u_cordic_heading (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (u2_v),
    .x_i    (u2_d),
    .y_i    ('0),
    .z_i    ({u2_side.heading, 16'b0}),
    .side_i (u2_s),
    .v_o    (r2_v),
    .x_o    (r2_x),
    .y_o    (r2_y),
    .z_o    (r2_z),
    .side_o (r2_s)
  );

  // Negated wind: air velocity minus ground velocity, ready for vectoring.
  always_comb begin
    r2_side = wte_pkg::side_b_t'(r2_s);
    w_x_d   = r2_x - $signed({{(CW-32){r2_side.gn[15]}}, r2_side.gn, 16'b0});
    w_y_d   = r2_y - $signed({{(CW-32){r2_side.ge[15]}}, r2_side.ge, 16'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
    end else begin
      w_v_q <= r2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    w_x_q      <= w_x_d;
    w_y_q      <= w_y_d;
    w_s_q.up   <= r2_side.up;
    w_s_q.calm <= (w_x_d == '0) && (w_y_d == '0);
    w_s_q.ok   <= r2_side.ok;
  end

  wte_cordic #(
    .STAGES (CORDIC_STAGES),
    .MODE   (wte_pkg::CORDIC_VECTOR),
    .SW     (SCW)
  ) u_cordic_vector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (w_v_q),
    .x_i    (w_x_q),
    .y_i    (w_y_q),
    .z_i    ('0),
    .side_i (w_s_q),
    .v_o    (r3_v),
    .x_o    (r3_x),
    .y_o    (r3_y),
    .z_o    (r3_z),
    .side_o (r3_s)
  );

  // Direction rounded to 16 bits; the residual y is not needed.
  always_comb begin
    r3_side         = wte_pkg::side_c_t'(r3_s);
    dir_rnd         = r3_z + 32'h0000_8000;
    u3_side_in.dir  = dir_rnd[31:16] | {16{r3_y[0] & 1'b0}};
    u3_side_in.up   = r3_side.up;
    u3_side_in.calm = r3_side.calm;
    u3_side_in.ok   = r3_side.ok;
  end

  wte_unscale #(.SW(SDW)) u_unscale_speed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (r3_v),
    .d_i    (r3_x),
    .side_i (u3_side_in),
    .v_o    (u3_v),
    .d_o    (u3_d),
    .side_o (u3_s)
  );

  // Output assembly with the low airspeed and calm wind cases.
  always_comb begin
    u3_side = wte_pkg::side_d_t'(u3_s);
    out_d   = '0;
    if (u3_side.ok) begin
      out_d.valid_res     = 1'b1;
      out_d.wind_vertical = u3_side.up;
      if (!u3_side.calm) begin
        out_d.wind_speed    = wte_pkg::round_sat_u16(u3_d);
        out_d.wind_from_dir = u3_side.dir;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= u3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

// File: dv/wind_triangle_checker.sv
// Checker that predicts the wind estimate for each accepted sample and compares the results.
`timescale 1ns / 1ps

module wind_triangle_checker #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_o,
  input  wte_pkg::in_t  item_i,
  input  logic          cfg_we_i,
  input  logic [14:0]   cfg_wdata_i,
  input  logic          res_valid_o,
  input  wte_pkg::res_t res_o,
  output int            fail_count_o,
  output int            pending_o
);
  import wte_pkg::*;

  localparam longint unsigned InvGain = 64'd652032874;

  logic [14:0] airspeed_floor;
  res_t        wind_queue[$];
  int          mismatch_count;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] arctan_step(input int i);
    logic [31:0] tab [24];
    tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return tab[i];
  endfunction

  // Multiply by the reciprocal gain and floor, sign handled on the magnitude.
  function automatic longint remove_gain(input longint v);
    longint unsigned mag;
    longint unsigned p;
    longint          r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    p = mag * InvGain;
    if (v < 0) r = (-longint'(p)) >>> 30;
    else r = longint'(p >> 30);
    return r;
  endfunction

  // Turn the vector (x0, 0) through angle a.
  function automatic void turn_vector(input longint x0, input logic [31:0] a,
                                      output longint xc, output longint ys);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    x = remove_gain(x0);
    y = 0;
    z = a;
    if (32'(z + QUARTER_TURN) >= HALF_TURN) begin
      x = -x;
      z = z + HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[31]) begin
        x -= dx; y += dy; z = z - arctan_step(i);
      end else begin
        x += dx; y -= dy; z = z + arctan_step(i);
      end
    end
    xc = x;
    ys = y;
  endfunction

  // Rotate (x, y) onto the x axis, giving scaled magnitude and angle.
  function automatic void polar_of(input longint xi, input longint yi,
                                   output longint mag, output logic [31:0] ang);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z = z + arctan_step(i);
      end else begin
        x -= dx; y += dy; z = z - arctan_step(i);
      end
    end
    mag = x;
    ang = z;
  endfunction

  // Expected wind estimate for one sample.
  function automatic res_t estimate_wind(input in_t s);
    res_t        r;
    longint      horiz, vsin, airn, aire, wn, we, up, mag, spd;
    logic [31:0] dir;
    r = '0;
    if (s.true_airspeed < airspeed_floor) return r;
    turn_vector(longint'(s.true_airspeed) * 65536, {s.pitch_angle, 16'h0}, horiz, vsin);
    turn_vector(horiz, {s.heading_angle, 16'h0}, airn, aire);
    wn = longint'(s.ground_vel_north) * 65536 - airn;
    we = longint'(s.ground_vel_east) * 65536 - aire;
    up = -(longint'(s.ground_vel_down) * 65536 + vsin);
    if (wn == 0 && we == 0) begin
      spd = 0;
      dir = '0;
    end else begin
      polar_of(-wn, -we, mag, dir);
      spd = (remove_gain(mag) + 32768) >>> 16;
      if (spd > 65535) spd = 65535;
      if (spd < 0) spd = 0;
      dir = (dir + 32'h8000) >> 16;
    end
    up = (up + 32768) >>> 16;
    if (up > 32767) up = 32767;
    if (up < -32768) up = -32768;
    r.valid_res     = 1'b1;
    r.wind_speed    = spd[15:0];
    r.wind_from_dir = dir[15:0];
    r.wind_vertical = up[15:0];
    return r;
  endfunction

  // Register shadow, prediction on each transfer and comparison of results.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      airspeed_floor = MIN_AIRSPEED_RESET;
      wind_queue.delete();
      mismatch_count = 0;
    end else begin
      if (res_valid_o) begin
        if (wind_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result %h", $realtime, res_o);
        end else begin
          want = wind_queue.pop_front();
          if (res_o.valid_res !== want.valid_res || res_o.wind_speed !== want.wind_speed ||
              res_o.wind_from_dir !== want.wind_from_dir ||
              res_o.wind_vertical !== want.wind_vertical) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: wind mismatch: expected v=%0d spd=%0d dir=%0d up=%0d,",
                       $realtime, want.valid_res, want.wind_speed, want.wind_from_dir,
                       want.wind_vertical,
                       " got v=%0d spd=%0d dir=%0d up=%0d",
                       res_o.valid_res, res_o.wind_speed,
                       res_o.wind_from_dir, res_o.wind_vertical);
          end
        end
      end
      if (start_i && !busy_o) wind_queue.push_back(estimate_wind(item_i));
      if (cfg_we_i) airspeed_floor = cfg_wdata_i;
    end
    pending_o = wind_queue.size();
  end

  // Results left over are counted as failures by the top at the end.
  assign fail_count_o = mismatch_count;
endmodule

// File: dv/tb.sv
// Testbench top for the wind triangle estimator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb;
  import wte_pkg::*;

  localparam int unsigned Latency = 3 * 16 + 12;
  localparam int unsigned StallLimit = 2000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  in_t           item_i = '0;
  logic          cfg_we_i = 1'b0;
  logic [14:0]   cfg_wdata_i = '0;
  logic          res_valid_o;
  res_t          res_o;
  int            fail_count;
  int            pending;
  int            idle_cycles;
  int            sample_count;
  int            calm_count;

  always #6 clk_i = ~clk_i;

  wind_triangle_estimator_unit i_dut (.*);

  wind_triangle_checker i_chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .cfg_we_i, .cfg_wdata_i,
    .res_valid_o, .res_o, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on cycles with no transfer in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Present one sample after a random gap and hold it until the transfer.
  task automatic send_sample(input in_t s, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= s;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sample_count++;
  endtask

  // Wait for all results, then the pipeline depth, before touching the register.
  task automatic write_floor(input logic [14:0] v);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_t random_sample(input int mode);
    in_t s;
    s.ground_vel_north = 16'($urandom);
    s.ground_vel_east  = 16'($urandom);
    s.ground_vel_down  = 16'($urandom);
    s.heading_angle    = 16'($urandom);
    s.pitch_angle      = 16'($urandom);
    s.true_airspeed    = 15'($urandom);
    // Most samples look like flight: modest pitch and airspeed near ground speed.
    if (mode < 6) begin
      s.pitch_angle      = 16'($urandom_range(0, 8191) - 4096);
      s.true_airspeed    = 15'($urandom_range(0, 12000));
      s.ground_vel_north = 16'($urandom_range(0, 16000) - 8000);
      s.ground_vel_east  = 16'($urandom_range(0, 16000) - 8000);
      s.ground_vel_down  = 16'($urandom_range(0, 2000) - 1000);
    end
    return s;
  endfunction

  initial begin
    in_t  s;
    logic [14:0] floors [4];
    floors = '{15'd0, 15'h7FFF, 15'd5000, 15'd300};
    sample_count = 0;
    calm_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples at the reset floor: field extremes, low airspeed, level flight.
    s = '0;
    send_sample(s, 1'b0);
    s.true_airspeed = 15'd1279;
    send_sample(s, 1'b0);
    s.true_airspeed = 15'd1280;
    send_sample(s, 1'b1);
    s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'sh7FFF, 15'h7FFF};
    send_sample(s, 1'b0);
    s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 16'sh8000, 15'h7FFF};
    send_sample(s, 1'b1);
    s = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'h8000, 16'sh4000, 15'h7FFF};
    send_sample(s, 1'b0);
    s = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h4000, 16'shC000, 15'h7FFF};
    send_sample(s, 1'b1);
    // Level flight due north with matching ground speed: nearly calm horizontal wind.
    s = '{16'sd2560, 16'sd0, 16'sd0, 16'h0000, 16'sd0, 15'd2560};
    send_sample(s, 1'b0);
    s = '{16'sd0, 16'sd0, -16'sd500, 16'hC000, 16'sh6000, 15'd4000};
    send_sample(s, 1'b0);
    s = '{16'sd100, -16'sd100, 16'sd50, 16'h2000, -16'sh6000, 15'd20000};
    send_sample(s, 1'b0);

    // Random phases at several floor settings, extremes included.
    for (int p = 0; p < 4; p++) begin
      write_floor(floors[p]);
      // With a zero floor, still air and zero airspeed give exactly calm wind.
      if (floors[p] == 15'd0) begin
        s = '0;
        send_sample(s, 1'b0);
        calm_count++;
      end
      for (int n = 0; n < 160; n++) send_sample(random_sample($urandom_range(0, 9)),
                                                 ($urandom_range(0, 3) == 0));
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    $display("Covered %0d samples over five airspeed floor settings, %0d calm-wind cases.",
             sample_count, calm_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// File: wind_triangle_estimator_unit.f
sv/wte_pkg.sv
sv/wte_unscale.sv
sv/wte_cordic.sv
sv/wind_triangle_estimator_unit.sv
dv/wind_triangle_checker.sv
dv/tb.sv
